// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the decoder project.
// Needs nothing else; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/utf8bl_pkg.sv =====
// Package for the byte-level token decoder: widths, codepoint ranges and
// the codepoint to raw byte mapping. Depends on nothing.
package utf8bl_pkg;

  localparam int ByteW  = 8;
  localparam int CodeW  = 21;
  localparam int LeftW  = 2;

  localparam logic [CodeW-1:0] CpPrintLo  = 21'd33;
  localparam logic [CodeW-1:0] CpPrintHi  = 21'd126;
  localparam logic [CodeW-1:0] CpLatinLo  = 21'd161;
  localparam logic [CodeW-1:0] CpLatinMid = 21'd172;
  localparam logic [CodeW-1:0] CpShy      = 21'd173;
  localparam logic [CodeW-1:0] CpLatinHi  = 21'd174;
  localparam logic [CodeW-1:0] CpByteMax  = 21'd255;
  localparam logic [CodeW-1:0] CpCtrlLo   = 21'd256;
  localparam logic [CodeW-1:0] CpCtrlHi   = 21'd288;
  localparam logic [CodeW-1:0] CpHighLo   = 21'd289;
  localparam logic [CodeW-1:0] CpHighHi   = 21'd322;
  localparam logic [CodeW-1:0] CpShyCode  = 21'd323;
  localparam logic [8:0]       HighOffset = 9'd162;
  localparam logic [ByteW-1:0] ShyByte    = 8'd173;

  typedef struct packed {
    logic             hit;
    logic [ByteW-1:0] value;
  } map_t;

  function automatic map_t map_code(input logic [CodeW-1:0] cp);
    map_t       res;
    logic [8:0] high_diff;
    high_diff = cp[8:0] - HighOffset;
    res.hit   = 1'b1;
    res.value = cp[ByteW-1:0];
    if ((cp >= CpPrintLo && cp <= CpPrintHi) || (cp >= CpLatinLo && cp <= CpLatinMid) ||
        (cp >= CpLatinHi && cp <= CpByteMax)) begin
      res.value = cp[ByteW-1:0];
    end else if (cp >= CpCtrlLo && cp <= CpCtrlHi) begin
      res.value = cp[ByteW-1:0];
    end else if (cp >= CpHighLo && cp <= CpHighHi) begin
      res.value = high_diff[ByteW-1:0];
    end else if (cp == CpShyCode) begin
      res.value = ShyByte;
    end else begin
      res.hit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== rtl/utf8bl_if.sv =====
// Valid/ready channels of the byte-level token decoder.
// Depends on utf8bl_pkg for the byte width.
interface utf8bl_in_if;
  logic                         valid;
  logic                         ready;
  logic [utf8bl_pkg::ByteW-1:0] in_byte;
  logic                         string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

interface utf8bl_out_if;
  logic                         valid;
  logic                         ready;
  logic [utf8bl_pkg::ByteW-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

// ===== rtl/utf8_byte_level_token_decoder.sv =====
// Byte-level token decoder: UTF-8 bytes in, raw bytes out; uses utf8bl_pkg, utf8bl_if.
// Each byte passes the input register, then is decoded and mapped into the result
// register. Throughput: one byte per cycle while the output is not stalled, set by the
// single decode stage; bytes whose codepoint is open or dropped give no item.
// Reset (rst_ni low, asynchronous) empties both registers and closes any open sequence.
module utf8_byte_level_token_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8bl_in_if.sink     in_i,
  utf8bl_out_if.source  out_o
);

  logic                                 s1_valid_q;
  logic [utf8bl_pkg::ByteW-1:0]         s1_byte_q;
  logic                                 s1_last_q;
  logic [utf8bl_pkg::CodeW-1:0]         partial_q, partial_d;
  logic [utf8bl_pkg::LeftW-1:0]         left_q, left_d;
  logic                                 out_valid_q, out_valid_d;
  logic [utf8bl_pkg::ByteW-1:0]         out_byte_q, out_byte_d;

  logic                                 advance;
  logic                                 emit;
  logic [utf8bl_pkg::CodeW-1:0]         code;
  logic [utf8bl_pkg::LeftW-1:0]         left;
  utf8bl_pkg::map_t                     mapped;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_comb begin
    if (left_q == '0) begin
      if (!s1_byte_q[7]) begin
        code = {13'd0, s1_byte_q};
        left = 2'd0;
      end else if (s1_byte_q[7:5] == 3'b110) begin
        code = {16'd0, s1_byte_q[4:0]};
        left = 2'd1;
      end else if (s1_byte_q[7:4] == 4'b1110) begin
        code = {17'd0, s1_byte_q[3:0]};
        left = 2'd2;
      end else begin
        code = {18'd0, s1_byte_q[2:0]};
        left = 2'd3;
      end
    end else begin
      code = {partial_q[14:0], s1_byte_q[5:0]};
      left = left_q - 2'd1;
    end
    emit   = (left == '0) || s1_last_q;
    mapped = utf8bl_pkg::map_code(code);

    partial_d   = partial_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    if (advance) begin
      if (emit) begin
        partial_d = '0;
        left_d    = '0;
        if (mapped.hit) begin
          out_valid_d = 1'b1;
          out_byte_d  = mapped.value;
        end
      end else begin
        partial_d = code;
        left_d    = left;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      partial_q   <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      partial_q   <= partial_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.string_end;
    end
    out_byte_q <= out_byte_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;

endmodule

// ===== rtl/utf8bl_checker.sv =====
// Port-level checks for the byte-level token decoder, bound to its top level.
// Depends on assert_macros.svh and the channel interfaces of the top level.
`include "assert_macros.svh"

module utf8bl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i
);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "Result item dropped before it was taken.")
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_byte_i), "Result item changed while stalled.")
  `ASSERT_IMP(a_ready_only_stall, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i, "Input stalled while the output side could move.")
  `ASSERT_IMP(a_result_source, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "Result item without an item accepted two cycles before.")

endmodule

bind utf8_byte_level_token_decoder utf8bl_checker u_utf8bl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte)
);
